@@ rtl/fwbtp_pkg.sv @@
`timescale 1ns / 1ps
package fwbtp_pkg;
  localparam int TableEntries = 64;
  localparam int IdxW = $clog2(TableEntries);
  localparam int MaxWindowBytes = 64;
  localparam int QueueDepth = 2;

  localparam logic [1:0] StatusPredict = 2'd0;
  localparam logic [1:0] StatusInsert = 2'd1;
  localparam logic [1:0] StatusCorrect = 2'd2;
  localparam logic [1:0] StatusMispredict = 2'd3;

  localparam logic [0:0] CfgMode = 1'd0;
  localparam logic [0:0] CfgStep = 1'd1;

  localparam logic ActionPredict = 1'b0;

  typedef struct packed {
    logic        action;
    logic [63:0] pc;
    logic [6:0]  window_len;
    logic [63:0] actual_target;
  } in_item_t;

  typedef struct packed {
    logic        found_entry;
    logic        predict_taken;
    logic [6:0]  fetch_len;
    logic [63:0] pred_target;
    logic [1:0]  update_status;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } exec_state_t;

  typedef struct packed {
    logic        action;
    logic [63:0] pc;
    logic [6:0]  window_len;
    logic [6:0]  limit;
    logic [63:0] actual_target;
  } cmd_t;
endpackage

@@ rtl/fetch_window_branch_target_predictor.sv @@
`timescale 1ns / 1ps
// Fetch-window branch target predictor, fully associative, 64 entries.
// Input channel (in_valid/in_stall/in_data): predict or update transactions.
// Output channel (out_valid/out_stall/out_data): one result per transaction.
// Config port (cfg_we/cfg_index/cfg_data): 0 predictor mode, 1 instruction step.
// A two-entry queue decouples acceptance from execution, so inputs are
// taken while a result waits on a stalled receiver.
// Update: the queue head passes through ST_IDLE, ST_UPDATE and ST_DONE. Predict:
// ST_IDLE, then ST_SCAN over up to 64 window slots (window/step), one slot compared
// against all entries per cycle, then ST_DONE; no new transaction starts until then.
// Reset empties the table, clears the replacement pointer, sets counter
// mode and a step of 4. A stalled result holds; the queue then fills and
// in_stall rises.
module fetch_window_branch_target_predictor import fwbtp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [4:0] cfg_data
);
  logic mode;
  logic [4:0] step;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
      step <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgMode: mode <= cfg_data[0];
        CfgStep: step <= cfg_data;
        default: ;
      endcase
    end
  end

  fwbtp_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
  );

  fwbtp_back u_back (
    .clk(clk), .rst(rst), .mode(mode), .step(step), .cmd_valid(cmd_valid),
    .cmd_pop(cmd_pop), .cmd(cmd), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("pop from empty queue");
  a_update_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.update_status != StatusPredict |->
    !out_data.found_entry && !out_data.predict_taken)
    else $error("update result carries prediction");
endmodule

@@ rtl/fwbtp_front.sv @@
`timescale 1ns / 1ps
module fwbtp_front import fwbtp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_pop,
  output cmd_t     cmd
);
  localparam int PtrW = $clog2(QueueDepth);
  cmd_t q [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0] count;
  cmd_t cmd_in;
  logic push, pop;

  always_comb begin
    cmd_in.action = in_data.action;
    cmd_in.pc = in_data.pc;
    cmd_in.window_len = in_data.window_len;
    cmd_in.limit = (in_data.window_len > 7'(MaxWindowBytes)) ?
                   7'(MaxWindowBytes) : in_data.window_len;
    cmd_in.actual_target = in_data.actual_target;
  end

  assign in_stall = (count == (PtrW+1)'(QueueDepth));
  assign push = in_valid && !in_stall;
  assign pop = cmd_pop && cmd_valid;
  assign cmd_valid = (count != '0);
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

@@ rtl/fwbtp_back.sv @@
`timescale 1ns / 1ps
module fwbtp_back import fwbtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        mode,
  input  logic [4:0]  step,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);
  logic [TableEntries-1:0] valid_bits;
  logic [63:0] tags [TableEntries];
  logic [63:0] targets [TableEntries];
  logic [1:0]  ctrs [TableEntries];
  logic [IdxW-1:0] replace_pointer;

  exec_state_t state, state_next;
  cmd_t cur;
  logic [7:0] offs;
  out_item_t res;

  logic [5:0] stepv;
  logic [63:0] probe;
  logic hit;
  logic [IdxW-1:0] hit_idx;
  logic have_free;
  logic [IdxW-1:0] free_idx;
  logic [63:0] fall;
  logic [7:0] trim;

  assign stepv = (step == 5'd0) ? 6'd1 : {1'b0, step};
  assign probe = (cur.action == ActionPredict) ? cur.pc + 64'(offs) : cur.pc;
  assign fall = cur.pc + 64'(stepv);
  assign trim = offs + 8'(stepv);

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    have_free = 1'b0;
    free_idx = '0;
    for (int k = TableEntries - 1; k >= 0; k--) begin
      if (valid_bits[k] && tags[k] == probe) begin
        hit = 1'b1;
        hit_idx = IdxW'(k);
      end
      if (!valid_bits[k]) begin
        have_free = 1'b1;
        free_idx = IdxW'(k);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (cmd_valid) state_next = cmd.action == ActionPredict ? ST_SCAN : ST_UPDATE;
      ST_SCAN: if (hit || offs + 8'(stepv) >= {1'b0, cur.limit} || {1'b0, cur.limit} <= offs)
                 state_next = ST_DONE;
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state == ST_IDLE) && cmd_valid;
    out_valid = (state == ST_DONE);
    out_data = res;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      replace_pointer <= '0;
    end else if (state == ST_UPDATE && !hit) begin
      if (have_free) valid_bits[free_idx] <= 1'b1;
      else replace_pointer <= replace_pointer + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur <= cmd;
        offs <= '0;
        res.found_entry <= 1'b0;
        res.predict_taken <= 1'b0;
        res.fetch_len <= (cmd.action == ActionPredict) ? cmd.window_len : 7'd0;
        res.pred_target <= '0;
        res.update_status <= StatusPredict;
      end
      ST_SCAN: begin
        if ({1'b0, cur.limit} > offs) begin
          if (hit) begin
            res.found_entry <= 1'b1;
            if (!mode || ctrs[hit_idx][1]) begin
              res.predict_taken <= 1'b1;
              res.fetch_len <= (trim > 8'd127) ? 7'd127 : trim[6:0];
              res.pred_target <= targets[hit_idx];
            end
          end
          offs <= offs + 8'(stepv);
        end
      end
      ST_UPDATE: begin
        if (!hit) begin
          tags[have_free ? free_idx : replace_pointer] <= cur.pc;
          targets[have_free ? free_idx : replace_pointer] <= cur.actual_target;
          ctrs[have_free ? free_idx : replace_pointer] <=
            (cur.actual_target == fall) ? 2'd1 : 2'd2;
          res.update_status <= StatusInsert;
        end else if (!mode) begin
          if (targets[hit_idx] != cur.actual_target) begin
            targets[hit_idx] <= cur.actual_target;
            res.update_status <= StatusMispredict;
          end else res.update_status <= StatusCorrect;
        end else if (ctrs[hit_idx][1]) begin
          if (cur.actual_target != targets[hit_idx]) begin
            ctrs[hit_idx] <= ctrs[hit_idx] - 2'd1;
            if (ctrs[hit_idx] == 2'd3 && cur.actual_target != fall)
              targets[hit_idx] <= cur.actual_target;
            res.update_status <= StatusMispredict;
          end else begin
            if (ctrs[hit_idx] != 2'd3) ctrs[hit_idx] <= ctrs[hit_idx] + 2'd1;
            res.update_status <= StatusCorrect;
          end
        end else begin
          if (cur.actual_target != fall) begin
            ctrs[hit_idx] <= ctrs[hit_idx] + 2'd1;
            targets[hit_idx] <= cur.actual_target;
            res.update_status <= StatusMispredict;
          end else begin
            if (ctrs[hit_idx] != 2'd0) ctrs[hit_idx] <= ctrs[hit_idx] - 2'd1;
            res.update_status <= StatusCorrect;
          end
        end
      end
      default: ;
    endcase
  end
endmodule
